[design/wpf_pkg.sv]
// Package for the waveform peak finder: shared constants, register indexes
// and the record that travels from the front end through the queue to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpf_pkg;

	// Parameter defaults
	localparam int NUM_SAMPLES_DEF = 128;
	localparam int MAX_PEAKS_DEF   = 8;

	// Field widths
	localparam int SAMPLE_W    = 16;
	localparam int INDEX_W     = 8;
	localparam int TOTAL_W     = 4;
	localparam int HOLDOFF_W   = 3;
	localparam int TREF_W      = 15;
	localparam int TOL_W       = 14;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 15;

	// Window: the four stored samples plus the current one
	localparam int WIN_DEPTH   = 4;
	// Samples skipped after a hit so the next window shares none
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_LOAD = 3'd4;
	// One sample is 4 ns = 64 ticks of 1/16 ns
	localparam int TIME_SHIFT  = 6;
	localparam logic [INDEX_W-1:0] INDEX_MAX = 8'd255;
	// Goodness arithmetic width: shifted time plus two signed offsets
	localparam int DIFF_W      = INDEX_W + TIME_SHIFT + 5;

	localparam logic [TOL_W-1:0] TOL_RESET = 14'd160;

	// Depth of the front-to-back queue
	localparam int QDEPTH      = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET    = 1'd1;

	// One classified item: a peak, a summary request or both
	typedef struct packed {
		logic                        hit;
		logic                        last;
		logic signed [SAMPLE_W-1:0]  amp;
		logic [INDEX_W-1:0]          peak_t;
		logic signed [TREF_W-1:0]    blk_ref;
		logic [TOTAL_W-1:0]          total;
		logic                        ovf;
	} entry_t;

	// Queue status seen by its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[design/wpf_if.sv]
// Channel interfaces of the waveform peak finder: sample input, result output
// and configuration write. Depends on wpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wpf_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [wpf_pkg::SAMPLE_W-1:0]  sample;
	logic                                 first_sample;
	logic                                 last_sample;
	logic signed [wpf_pkg::TREF_W-1:0]    block_time_ref;

	modport source(output valid, sample, first_sample, last_sample, block_time_ref,
		input ready);
	modport sink(input valid, sample, first_sample, last_sample, block_time_ref,
		output ready);
endinterface

interface wpf_result_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 is_summary;
	logic signed [wpf_pkg::SAMPLE_W-1:0]  peak_amplitude;
	logic [wpf_pkg::INDEX_W-1:0]          peak_time;
	logic                                 peak_good;
	logic [wpf_pkg::TOTAL_W-1:0]          peak_total;
	logic                                 peak_overflow;
	logic                                 last_of_run;

	modport source(output valid, is_summary, peak_amplitude, peak_time, peak_good,
		peak_total, peak_overflow, last_of_run, input ready);
	modport sink(input valid, is_summary, peak_amplitude, peak_time, peak_good,
		peak_total, peak_overflow, last_of_run, output ready);
endinterface

interface wpf_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [wpf_pkg::CFG_IDX_W-1:0]        index;
	logic [wpf_pkg::CFG_DATA_W-1:0]       data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/wpf_front.sv]
// Front end of the peak finder: takes samples, keeps the window and scan state,
// and classifies each sample into a queue entry. Depends on wpf_pkg, wpf_if.
`timescale 1ns / 1ps
`default_nettype none

module wpf_front #(
	parameter int NUM_SAMPLES = wpf_pkg::NUM_SAMPLES_DEF,
	parameter int MAX_PEAKS   = wpf_pkg::MAX_PEAKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	wpf_sample_if.sink       samples,
	input  wpf_pkg::q_stat_t q_stat,
	output logic             push,
	output wpf_pkg::entry_t  push_entry
);

	localparam logic [wpf_pkg::INDEX_W-1:0] LAST_END = wpf_pkg::INDEX_W'(NUM_SAMPLES - 3);
	localparam logic [wpf_pkg::INDEX_W-1:0] MIN_END  = wpf_pkg::INDEX_W'(wpf_pkg::WIN_DEPTH);
	localparam logic [wpf_pkg::TOTAL_W-1:0] PEAK_CAP = wpf_pkg::TOTAL_W'(MAX_PEAKS);

	logic signed [wpf_pkg::SAMPLE_W-1:0] win_q [wpf_pkg::WIN_DEPTH];
	logic [wpf_pkg::INDEX_W-1:0]         idx_q;
	logic [wpf_pkg::HOLDOFF_W-1:0]       hold_q;
	logic [wpf_pkg::TOTAL_W-1:0]         peaks_q;
	logic                                ovf_q;
	logic signed [wpf_pkg::TREF_W-1:0]   ref_q;

	logic                                accept;
	logic [wpf_pkg::INDEX_W-1:0]         idx_cur;
	logic [wpf_pkg::HOLDOFF_W-1:0]       hold_cur;
	logic [wpf_pkg::TOTAL_W-1:0]         peaks_cur;
	logic                                ovf_cur;
	logic signed [wpf_pkg::TREF_W-1:0]   ref_cur;
	logic                                window_ok;
	logic                                match;
	logic                                found;
	logic                                hit;
	logic [wpf_pkg::HOLDOFF_W-1:0]       hold_nx;
	logic [wpf_pkg::TOTAL_W-1:0]         peaks_nx;
	logic                                ovf_nx;
	logic [wpf_pkg::INDEX_W-1:0]         idx_nx;

	// Accept whenever the queue has room
	assign samples.ready = !q_stat.full;
	assign accept        = samples.valid && samples.ready;

	// Restart the scan state on a first-sample mark
	always_comb begin
		if (samples.first_sample) begin
			idx_cur   = '0;
			hold_cur  = '0;
			peaks_cur = '0;
			ovf_cur   = 1'b0;
			ref_cur   = samples.block_time_ref;
		end else begin
			idx_cur   = idx_q;
			hold_cur  = hold_q;
			peaks_cur = peaks_q;
			ovf_cur   = ovf_q;
			ref_cur   = ref_q;
		end
	end

	// Classify the five-sample window ending at the current sample
	always_comb begin
		window_ok = (idx_cur >= MIN_END) && (idx_cur <= LAST_END) &&
			(hold_cur == '0) && !ovf_cur;
		match = (win_q[0] < win_q[1]) && (win_q[1] < win_q[2]) &&
			(win_q[2] <= win_q[3]) && (win_q[3] >= samples.sample) &&
			(samples.sample > 0);
		found = window_ok && match;
		hit   = found && (peaks_cur < PEAK_CAP);
	end

	// Next scan state
	always_comb begin
		if (hit) begin
			hold_nx = wpf_pkg::HOLDOFF_LOAD;
		end else if (hold_cur != '0) begin
			hold_nx = hold_cur - 1'b1;
		end else begin
			hold_nx = '0;
		end
		peaks_nx = peaks_cur + wpf_pkg::TOTAL_W'(hit);
		ovf_nx   = ovf_cur || (found && !hit);
		idx_nx   = (idx_cur == wpf_pkg::INDEX_MAX) ? idx_cur : idx_cur + 1'b1;
	end

	// Queue entry: only samples that give a result are pushed
	always_comb begin
		push              = accept && (hit || samples.last_sample);
		push_entry.hit    = hit;
		push_entry.last   = samples.last_sample;
		push_entry.amp    = win_q[3];
		push_entry.peak_t = idx_cur - 1'b1;
		push_entry.blk_ref = ref_cur;
		push_entry.total  = peaks_nx;
		push_entry.ovf    = ovf_nx;
	end

	// Advance window and scan state per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wpf_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			idx_q   <= '0;
			hold_q  <= '0;
			peaks_q <= '0;
			ovf_q   <= 1'b0;
			ref_q   <= '0;
		end else if (accept) begin
			for (int i = 0; i < wpf_pkg::WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[wpf_pkg::WIN_DEPTH-1] <= samples.sample;
			idx_q   <= idx_nx;
			hold_q  <= hold_nx;
			peaks_q <= peaks_nx;
			ovf_q   <= ovf_nx;
			ref_q   <= ref_cur;
		end
	end

endmodule

`default_nettype wire

[design/wpf_queue.sv]
// Short FIFO between the front and back ends of the peak finder.
// Depends on wpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wpf_pkg::entry_t   push_entry,
	input  logic              pop,
	output wpf_pkg::entry_t   head,
	output wpf_pkg::q_stat_t  q_stat
);

	localparam int PTR_W = $clog2(wpf_pkg::QDEPTH);
	localparam int CNT_W = $clog2(wpf_pkg::QDEPTH + 1);

	wpf_pkg::entry_t   mem_q [wpf_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign q_stat.full  = (count_q == CNT_W'(wpf_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/wpf_back.sv]
// Back end of the peak finder: drains queue entries into peak and summary
// results, grades peak timing, and holds the output register. Depends on wpf_pkg, wpf_if.
`timescale 1ns / 1ps
`default_nettype none

module wpf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wpf_pkg::entry_t                   head,
	input  wpf_pkg::q_stat_t                  q_stat,
	output logic                              pop,
	input  logic [wpf_pkg::TOL_W-1:0]         tolerance,
	input  logic signed [wpf_pkg::TREF_W-1:0] offset,
	wpf_result_if.source                      results
);

	localparam int DIFF_W = wpf_pkg::DIFF_W;

	logic                                res_v_q;
	logic                                phase_q;
	logic                                is_sum_q;
	logic signed [wpf_pkg::SAMPLE_W-1:0] amp_q;
	logic [wpf_pkg::INDEX_W-1:0]         time_q;
	logic                                good_q;
	logic [wpf_pkg::TOTAL_W-1:0]         total_q;
	logic                                ovf_q;
	logic                                lor_q;

	logic                                load;
	logic                                take;
	logic                                sum_now;
	logic signed [DIFF_W-1:0]            diff;
	logic [DIFF_W-1:0]                   mag;
	logic                                good;

	// Refill the output register when empty or being taken
	assign load    = !res_v_q || results.ready;
	assign take    = load && !q_stat.empty;
	// A peak goes out first; the summary follows from the same entry
	assign sum_now = phase_q || !head.hit;
	assign pop     = take && (sum_now || !head.last);

	// Grade the peak: |64*time - block ref - offset| < tolerance
	always_comb begin
		diff = $signed({{(DIFF_W - wpf_pkg::INDEX_W - wpf_pkg::TIME_SHIFT){1'b0}},
				head.peak_t, {wpf_pkg::TIME_SHIFT{1'b0}}})
			- DIFF_W'(head.blk_ref) - DIFF_W'(offset);
		mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		good = mag < DIFF_W'(tolerance);
	end

	// Output valid and entry phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			res_v_q <= !q_stat.empty;
			if (take) begin
				phase_q <= !sum_now && head.last;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (take) begin
			is_sum_q <= sum_now;
			amp_q    <= sum_now ? '0 : head.amp;
			time_q   <= sum_now ? '0 : head.peak_t;
			good_q   <= sum_now ? 1'b0 : good;
			total_q  <= head.total;
			ovf_q    <= head.ovf;
			lor_q    <= sum_now || !head.last;
		end
	end

	assign results.valid          = res_v_q;
	assign results.is_summary     = is_sum_q;
	assign results.peak_amplitude = amp_q;
	assign results.peak_time      = time_q;
	assign results.peak_good      = good_q;
	assign results.peak_total     = total_q;
	assign results.peak_overflow  = ovf_q;
	assign results.last_of_run    = lor_q;

endmodule

`default_nettype wire

[design/waveform_peak_finder_core.sv]
// Waveform peak finder top level: configuration registers, front end, queue and
// back end. Depends on wpf_pkg, wpf_if, wpf_front, wpf_queue, wpf_back.
//
// One sample is accepted per clock as long as the four-entry queue between the
// front and back ends has room. A sample whose five-sample window ending at it
// forms a peak (rising, rising, non-falling, non-rising, current sample positive)
// yields a peak report; a sample marked last yields a summary transaction after
// any peak report. The back end sends one result per clock while the receiver is
// ready, so a sample that gives both a peak and a summary sends two results, and
// the queue absorbs that. A result passes through the queue and then the output
// register before it appears. Configuration writes are always ready and take effect
// on the next cycle; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module waveform_peak_finder_core #(
	parameter int NUM_SAMPLES = wpf_pkg::NUM_SAMPLES_DEF,
	parameter int MAX_PEAKS   = wpf_pkg::MAX_PEAKS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	wpf_sample_if.sink   samples,
	wpf_result_if.source results,
	wpf_cfg_if.sink      cfg
);

	logic [wpf_pkg::TOL_W-1:0]         tol_q;
	logic signed [wpf_pkg::TREF_W-1:0] offset_q;

	logic             push;
	wpf_pkg::entry_t  push_entry;
	wpf_pkg::entry_t  head;
	wpf_pkg::q_stat_t q_stat;
	logic             pop;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= wpf_pkg::TOL_RESET;
			offset_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				wpf_pkg::REG_PEAK_TOLERANCE: tol_q    <= cfg.data[wpf_pkg::TOL_W-1:0];
				wpf_pkg::REG_TIME_OFFSET:    offset_q <= $signed(cfg.data);
				default: begin
					tol_q    <= tol_q;
					offset_q <= offset_q;
				end
			endcase
		end
	end

	wpf_front #(
		.NUM_SAMPLES(NUM_SAMPLES),
		.MAX_PEAKS  (MAX_PEAKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.q_stat    (q_stat),
		.push      (push),
		.push_entry(push_entry)
	);

	wpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	wpf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.tolerance(tol_q),
		.offset   (offset_q),
		.results  (results)
	);

endmodule

`default_nettype wire
